>>> hdl/pslf_pkg.sv
// Shared types and constants for the PI speed loop with feedforward.
// No dependencies; every other file in hdl/ refers to it by scoped name.
package pslf_pkg;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] REG_FF_GAIN    = 3'd2;
    localparam logic [2:0] REG_VEL_RECIP  = 3'd3;
    localparam logic [2:0] REG_PERIOD     = 3'd4;

    localparam logic [15:0] PROP_GAIN_RST  = 16'd102;
    localparam logic [15:0] INTEG_GAIN_RST = 16'd20;
    localparam logic [15:0] FF_GAIN_RST    = 16'd256;
    localparam logic [23:0] VEL_RECIP_RST  = 24'd16777;
    localparam logic [15:0] PERIOD_RST     = 16'd655;

    // Datapath constants
    localparam logic [7:0]          ANGLE_RST   = 8'd90;
    localparam logic [9:0]          PWM_MAX     = 10'd1023;
    localparam logic [15:0]         JUMP_LIMIT  = 16'd3276;      // 0.2 in Q2.14
    localparam logic signed [33:0]  INTEG_LIMIT = 34'sd1048576000; // 1000 in Q11.20

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_CMD  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] vel;     // raw measured velocity, mm/s
        logic [14:0]        tnorm;   // normalized target, Q2.14, 0..16384
        logic [7:0]         angle;
    } item_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] ff_gain;
        logic [23:0] vel_recip;
        logic [15:0] period;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_VEL,
        ST_ERR,
        ST_MUL_PER,
        ST_INTEG,
        ST_FF,
        ST_IGAIN,
        ST_PWM
    } back_state_t;

endpackage

>>> hdl/pslf_front.sv
// Front end: takes input items, classifies them and normalizes the target.
// Depends on pslf_pkg.
module pslf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // measured_velocity[15:0], target_speed[25:16],
                                           // steer_angle[33:26], zero pad
    input  logic                s_tuser,   // action: 0 tick, 1 command
    output logic                push,
    output pslf_pkg::item_t     push_item,
    input  logic                q_full
);

    logic            hold_valid_reg, hold_valid_next;
    pslf_pkg::item_t hold_item_reg,  hold_item_next;

    logic [9:0]  speed;
    logic [14:0] speed_x16;
    logic [14:0] y_plus1;
    logic [24:0] recip_prod;
    logic [14:0] tnorm;

    // round(speed * 16384 / 1023) = 16*speed + floor((16*speed + 511) / 1023);
    // the small quotient is exact as ((y + 1) * 1025) >> 20 over this range.
    assign speed      = s_tdata[25:16];
    assign speed_x16  = {1'b0, speed, 4'b0000};
    assign y_plus1    = speed_x16 + 15'd512;
    assign recip_prod = (25'(y_plus1) << 10) + 25'(y_plus1);
    assign tnorm      = speed_x16 + 15'(recip_prod[24:20]);

    assign push      = hold_valid_reg && !q_full;
    assign push_item = hold_item_reg;
    assign s_tready  = !hold_valid_reg || !q_full;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_item_next  = hold_item_reg;
        if (push) begin
            hold_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            hold_valid_next      = 1'b1;
            hold_item_next.kind  = pslf_pkg::kind_t'(s_tuser);
            hold_item_next.vel   = s_tdata[15:0];
            hold_item_next.tnorm = tnorm;
            hold_item_next.angle = s_tdata[33:26];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_item_reg <= hold_item_next;
    end

endmodule

>>> hdl/pslf_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on pslf_pkg.
module pslf_queue #(
    parameter int DEPTH = pslf_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pslf_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output pslf_pkg::item_t head_item,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pslf_pkg::item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/pslf_back.sv
// Back end: controller state and the tick sequence around one shared
// 32x25 signed multiplier, plus the result register. Depends on pslf_pkg.
module pslf_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  pslf_pkg::cfg_t   cfg,
    input  pslf_pkg::item_t  q_item,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata    // pwm_out[9:0], angle_out[17:10],
                                        // error_out[33:18], zero pad
);

    pslf_pkg::back_state_t state_reg, state_next;

    logic signed [31:0] acc_reg,   acc_next;    // Q11.20 integral
    logic [14:0]        tn_reg,    tn_next;     // Q2.14 target
    logic [7:0]         angle_reg, angle_next;
    logic signed [15:0] vel_reg,   vel_next;
    logic signed [15:0] err_reg,   err_next;
    logic signed [33:0] psum_reg,  psum_next;
    logic signed [56:0] prod_reg;

    logic               out_valid_reg, out_valid_next;
    logic [9:0]         pwm_out_reg,   pwm_out_next;
    logic [7:0]         angle_out_reg, angle_out_next;
    logic signed [15:0] err_out_reg,   err_out_next;

    logic signed [31:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [56:0] prod_next;

    logic signed [56:0] scaled;       // (prod + 1/2 lsb) >>> 10, floor
    logic signed [15:0] avel;
    logic signed [17:0] err_diff;
    logic signed [15:0] err_sat;
    logic signed [33:0] integ_sum;
    logic signed [33:0] integ_clamped;
    logic signed [15:0] tn_diff;
    logic [15:0]        tn_jump;
    logic signed [48:0] pwm_sum;
    logic [9:0]         pwm_val;

    function automatic logic signed [15:0] sat16(input logic signed [56:0] v);
        logic signed [15:0] r;
        if (v > 57'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -57'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign prod_next = 57'(mul_a) * 57'(mul_b);

    assign scaled    = (prod_reg + 57'sd512) >>> 10;
    assign avel      = sat16(scaled);
    assign err_diff  = $signed({3'b000, tn_reg}) - 18'(avel);
    assign err_sat   = sat16(57'(err_diff));

    assign integ_sum = 34'(acc_reg) + 34'(scaled);
    always_comb begin
        if (integ_sum > pslf_pkg::INTEG_LIMIT) begin
            integ_clamped = pslf_pkg::INTEG_LIMIT;
        end else if (integ_sum < -pslf_pkg::INTEG_LIMIT) begin
            integ_clamped = -pslf_pkg::INTEG_LIMIT;
        end else begin
            integ_clamped = integ_sum;
        end
    end

    assign tn_diff = $signed({1'b0, q_item.tnorm}) - $signed({1'b0, tn_reg});
    assign tn_jump = tn_diff[15] ? 16'(-tn_diff) : tn_diff;

    // Q.28 sum: (prop*err + ff*target) * 64 + igain*integral
    assign pwm_sum = (49'(psum_reg) <<< 6) + 49'(prod_reg);
    always_comb begin
        if (pwm_sum <= 49'sd0) begin
            pwm_val = '0;
        end else if (|pwm_sum[48:38]) begin
            pwm_val = pslf_pkg::PWM_MAX;
        end else begin
            pwm_val = pwm_sum[37:28];
        end
    end

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        tn_next        = tn_reg;
        angle_next     = angle_reg;
        vel_next       = vel_reg;
        err_next       = err_reg;
        psum_next      = psum_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        pwm_out_next   = pwm_out_reg;
        angle_out_next = angle_out_reg;
        err_out_next   = err_out_reg;
        // default operands keep the last product steady while the result waits
        mul_a          = acc_reg;
        mul_b          = {9'b0, cfg.integ_gain};

        unique case (state_reg)
            pslf_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_item.kind == pslf_pkg::KIND_CMD) begin
                        if (tn_jump > pslf_pkg::JUMP_LIMIT) begin
                            acc_next = '0;
                        end
                        tn_next    = q_item.tnorm;
                        angle_next = q_item.angle;
                    end else begin
                        vel_next   = q_item.vel;
                        state_next = pslf_pkg::ST_MUL_VEL;
                    end
                end
            end
            pslf_pkg::ST_MUL_VEL: begin
                mul_a      = 32'(vel_reg);
                mul_b      = {1'b0, cfg.vel_recip};
                state_next = pslf_pkg::ST_ERR;
            end
            pslf_pkg::ST_ERR: begin
                err_next   = err_sat;
                state_next = pslf_pkg::ST_MUL_PER;
            end
            pslf_pkg::ST_MUL_PER: begin
                mul_a      = 32'(err_reg);
                mul_b      = {9'b0, cfg.period};
                state_next = pslf_pkg::ST_INTEG;
            end
            pslf_pkg::ST_INTEG: begin
                acc_next   = 32'(integ_clamped);
                mul_a      = 32'(err_reg);
                mul_b      = {9'b0, cfg.prop_gain};
                state_next = pslf_pkg::ST_FF;
            end
            pslf_pkg::ST_FF: begin
                psum_next  = 34'(prod_reg);
                mul_a      = {17'b0, tn_reg};
                mul_b      = {9'b0, cfg.ff_gain};
                state_next = pslf_pkg::ST_IGAIN;
            end
            pslf_pkg::ST_IGAIN: begin
                psum_next  = psum_reg + 34'(prod_reg);
                state_next = pslf_pkg::ST_PWM;
            end
            pslf_pkg::ST_PWM: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    pwm_out_next   = pwm_val;
                    angle_out_next = angle_reg;
                    err_out_next   = err_reg;
                    state_next     = pslf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pslf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pslf_pkg::ST_IDLE;
            acc_reg       <= '0;
            tn_reg        <= '0;
            angle_reg     <= pslf_pkg::ANGLE_RST;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            tn_reg        <= tn_next;
            angle_reg     <= angle_next;
            out_valid_reg <= out_valid_next;
        end
        vel_reg       <= vel_next;
        err_reg       <= err_next;
        psum_reg      <= psum_next;
        prod_reg      <= prod_next;
        pwm_out_reg   <= pwm_out_next;
        angle_out_reg <= angle_out_next;
        err_out_reg   <= err_out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, err_out_reg, angle_out_reg, pwm_out_reg};

`ifndef SYNTHESIS
    a_integ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (34'(acc_reg) <= pslf_pkg::INTEG_LIMIT) && (34'(acc_reg) >= -pslf_pkg::INTEG_LIMIT))
        else $error("integral outside clamp range");

    a_vel_to_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pslf_pkg::ST_MUL_VEL) |=> (state_reg == pslf_pkg::ST_ERR))
        else $error("tick sequence did not advance to error step");

    a_result_from_pwm: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == pslf_pkg::ST_PWM))
        else $error("result raised outside the PWM step");

    a_cmd_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && (q_item.kind == pslf_pkg::KIND_CMD)) |=> (state_reg == pslf_pkg::ST_IDLE))
        else $error("command started a tick sequence");
`endif

endmodule

>>> hdl/pi_speed_loop_feedforward_core.sv
// Top level of the PI speed regulator with feedforward and integral clamp.
// Depends on pslf_pkg, pslf_front, pslf_queue and pslf_back.

// Speed regulator. Each item on the s_ stream is a target command
// (s_tuser = 1) or a measurement tick (s_tuser = 0). A command normalizes the
// target speed to Q2.14, stores it with the steering angle, clears the
// integral if the target steps by more than 0.2, and gives no result. A tick
// gives one result on the m_ stream: PWM duty 0..1023, the stored angle and
// the Q2.14 speed error. Timing: the front end registers each item it takes
// and hands it to a two-entry queue. The back end takes a command in its
// idle state and a tick in the dequeue plus seven sequencing steps around its
// single shared 32x25 multiplier, and takes no new item until they are done;
// the last step waits while a result sits in the output register. Input is
// still taken meanwhile, until the queue and the front end's hold register fill.
// Gains and periods sit in an APB register file (byte addresses 0x00..0x10,
// one 32-bit word per register); program them only while no item is in flight.
module pi_speed_loop_feedforward_core #(
    parameter int QUEUE_DEPTH = pslf_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // measured_velocity[15:0],
                                                    // target_speed[25:16],
                                                    // steer_angle[33:26], zero pad
    input  logic                          s_tuser,  // action: 0 tick, 1 command
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,  // pwm_out[9:0], angle_out[17:10],
                                                    // error_out[33:18], zero pad
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pslf_pkg::ADDR_W-1:0]   paddr,
    input  logic [pslf_pkg::DATA_W-1:0]   pwdata,
    output logic [pslf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    pslf_pkg::cfg_t  cfg_reg, cfg_next;
    logic            cfg_wr;
    logic [2:0]      reg_idx;

    logic            push;
    pslf_pkg::item_t push_item;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    pslf_pkg::item_t q_item;

    // ---------------------------------------------------------------
    // Register file: zero-wait APB, word-aligned, unused slots ignored
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_idx)
                pslf_pkg::REG_PROP_GAIN:  cfg_next.prop_gain  = pwdata[15:0];
                pslf_pkg::REG_INTEG_GAIN: cfg_next.integ_gain = pwdata[15:0];
                pslf_pkg::REG_FF_GAIN:    cfg_next.ff_gain    = pwdata[15:0];
                pslf_pkg::REG_VEL_RECIP:  cfg_next.vel_recip  = pwdata[23:0];
                pslf_pkg::REG_PERIOD:     cfg_next.period     = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pslf_pkg::REG_PROP_GAIN:  prdata = {16'b0, cfg_reg.prop_gain};
            pslf_pkg::REG_INTEG_GAIN: prdata = {16'b0, cfg_reg.integ_gain};
            pslf_pkg::REG_FF_GAIN:    prdata = {16'b0, cfg_reg.ff_gain};
            pslf_pkg::REG_VEL_RECIP:  prdata = {8'b0, cfg_reg.vel_recip};
            pslf_pkg::REG_PERIOD:     prdata = {16'b0, cfg_reg.period};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain  <= pslf_pkg::PROP_GAIN_RST;
            cfg_reg.integ_gain <= pslf_pkg::INTEG_GAIN_RST;
            cfg_reg.ff_gain    <= pslf_pkg::FF_GAIN_RST;
            cfg_reg.vel_recip  <= pslf_pkg::VEL_RECIP_RST;
            cfg_reg.period     <= pslf_pkg::PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Front end: take and classify, normalize the target
    // ---------------------------------------------------------------
    pslf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // Decouples the front end from the multi-cycle back end
    pslf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_item),
        .empty     (q_empty)
    );

    // ---------------------------------------------------------------
    // Back end: controller state, PI + feedforward, result register
    // ---------------------------------------------------------------
    pslf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_item   (q_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
